// File: design/dac_pkg.sv
// Shared types and constants for the drowsiness alert classifier.
// Holds register defaults, register indexes, status codes and stage structs.
// No dependencies.
package dac_pkg;

   // Fixed field widths
   localparam int CalibSeenW  = 5;
   localparam int CalibTotalW = 21;

   // Register defaults after reset
   localparam logic [8:0]         ALPHA_RESET     = 9'd77;
   localparam logic [15:0]        EAR_DEF_RESET   = 16'd1024;
   localparam logic [15:0]        MAR_RESET       = 16'd2458;
   localparam logic [13:0]        YAW_THR_RESET   = 14'd6400;
   localparam logic signed [14:0] PITCH_THR_RESET = 15'sd5120;
   localparam logic [15:0]        CLOSED_RESET    = 16'd1000;

   // Full weight of the new sample, and the lower bound of the learned threshold
   localparam logic [8:0]  ALPHA_FULL = 9'd256;
   localparam logic [15:0] EAR_FLOOR  = 16'd614;

   typedef enum logic [2:0] {
      REG_ALPHA     = 3'd0,
      REG_EAR_DEF   = 3'd1,
      REG_MAR       = 3'd2,
      REG_YAW_THR   = 3'd3,
      REG_PITCH_THR = 3'd4,
      REG_CLOSED    = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_ALERT = 3'd1,
      STATUS_YAWN  = 3'd2,
      STATUS_SIDE  = 3'd3,
      STATUS_DOWN  = 3'd4
   } status_type;

   typedef struct packed {
      logic [8:0]         alpha;
      logic [15:0]        ear_default;
      logic [15:0]        mar_thr;
      logic [13:0]        yaw_thr;
      logic signed [14:0] pitch_thr;
      logic [15:0]        closed_ms;
   } cfg_type;

   // Item leaving the smoothing stage
   typedef struct packed {
      logic [15:0]        eye_avg;
      logic [15:0]        mouth_avg;
      logic signed [14:0] yaw_avg;
      logic               pitch_down;
      logic [31:0]        time_ms;
   } smooth_type;

   // Item leaving the classification stage
   typedef struct packed {
      status_type  status;
      logic [15:0] blinks;
      logic [15:0] smoothed_eye;
      logic [15:0] eye_limit;
      logic        is_calibrated;
   } result_type;

endpackage

// File: design/dac_smooth.sv
// Smoothing stage: exponential averages of eye ratio, mouth ratio and yaw,
// plus the raw pitch compare, registered into the stage output.
// Depends on dac_pkg.
module dac_smooth (
   input  logic               clock,
   input  logic               reset,
   input  dac_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [15:0]        eye_ratio,
   input  logic [15:0]        mouth_ratio,
   input  logic signed [14:0] yaw_angle,
   input  logic signed [14:0] pitch_angle,
   input  logic [31:0]        time_ms,
   output logic               out_valid,
   input  logic               out_ready,
   output dac_pkg::smooth_type out_item
);
   import dac_pkg::*;

   logic [15:0]        eye_avg_ff, eye_avg_in;
   logic [15:0]        mouth_avg_ff, mouth_avg_in;
   logic signed [14:0] yaw_avg_ff, yaw_avg_in;
   logic               valid_ff;
   smooth_type         item_ff;

   logic [8:0]         weight;
   logic [8:0]         keep;
   logic signed [9:0]  weight_s;
   logic signed [9:0]  keep_s;
   logic [24:0]        eye_sum;
   logic [24:0]        mouth_sum;
   logic signed [24:0] yaw_old_p;
   logic signed [24:0] yaw_new_p;
   logic signed [25:0] yaw_sum;
   logic signed [25:0] yaw_shift;
   logic               accept;

   // Saturate the weight at a whole sample
   assign weight   = (cfg.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha;
   assign keep     = ALPHA_FULL - weight;
   assign weight_s = $signed({1'b0, weight});
   assign keep_s   = $signed({1'b0, keep});

   // Unsigned averages: the weighted sum stays below 2^24
   assign eye_sum    = 25'(eye_avg_ff) * 25'(keep) + 25'(eye_ratio) * 25'(weight);
   assign mouth_sum  = 25'(mouth_avg_ff) * 25'(keep) + 25'(mouth_ratio) * 25'(weight);
   assign eye_avg_in   = eye_sum[23:8];
   assign mouth_avg_in = mouth_sum[23:8];

   // Signed average: arithmetic shift rounds toward minus infinity
   assign yaw_old_p  = 25'(yaw_avg_ff) * 25'(keep_s);
   assign yaw_new_p  = 25'(yaw_angle) * 25'(weight_s);
   assign yaw_sum    = {yaw_old_p[24], yaw_old_p} + {yaw_new_p[24], yaw_new_p};
   assign yaw_shift  = yaw_sum >>> 8;
   assign yaw_avg_in = yaw_shift[14:0];

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Advance averages and the stage register on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_avg_ff   <= '0;
         mouth_avg_ff <= '0;
         yaw_avg_ff   <= '0;
         valid_ff     <= 1'b0;
      end else if (accept) begin
         eye_avg_ff   <= eye_avg_in;
         mouth_avg_ff <= mouth_avg_in;
         yaw_avg_ff   <= yaw_avg_in;
         valid_ff     <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.eye_avg    <= eye_avg_in;
         item_ff.mouth_avg  <= mouth_avg_in;
         item_ff.yaw_avg    <= yaw_avg_in;
         item_ff.pitch_down <= (pitch_angle > cfg.pitch_thr);
         item_ff.time_ms    <= time_ms;
      end
   end

endmodule

// File: design/dac_classify.sv
// Classification stage: calibration of the eye threshold, closure timing,
// blink count and status priority, registered into the result.
// Depends on dac_pkg.
module dac_classify #(
   parameter int CALIB_COUNT = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  dac_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  dac_pkg::smooth_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output dac_pkg::result_type out_item
);
   import dac_pkg::*;

   // floor(11*total / (20*CALIB_COUNT)) by reciprocal multiplication
   localparam int              Den     = 20 * CALIB_COUNT;
   localparam int              NumW    = CalibTotalW + 4;
   localparam int              DenW    = 10;
   localparam int              Shift   = NumW + DenW;
   localparam int              RecipW  = 31;
   localparam int              ProdW   = NumW + RecipW;
   localparam longint unsigned Recip   = ((64'd1 << Shift) + 64'(Den) - 64'd1) / 64'(Den);
   localparam logic [RecipW-1:0] RecipC = RecipW'(Recip);

   logic                   shut_ff, shut_in;
   logic [31:0]            since_ff, since_in;
   logic [15:0]            blinks_ff, blinks_in;
   logic [CalibSeenW-1:0]  seen_ff, seen_in;
   logic [CalibTotalW-1:0] total_ff, total_in;
   logic                   done_ff, done_in;
   logic [15:0]            learned_ff, learned_in;
   logic                   valid_ff;
   result_type             item_ff;

   logic [NumW-1:0]        numer;
   logic [ProdW-1:0]       prod;
   logic [CalibTotalW-1:0] quot;
   logic [15:0]            thr_calc;
   logic [15:0]            limit;
   logic [31:0]            elapsed;
   logic [14:0]            yaw_abs;
   status_type             status;
   logic                   accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Learned threshold from the running sum including this frame
   assign total_in = total_ff + CalibTotalW'(in_item.eye_avg);
   assign numer    = NumW'(total_in) * NumW'(11);
   assign prod     = ProdW'(numer) * ProdW'(RecipC);
   assign quot     = prod[Shift +: CalibTotalW];
   assign thr_calc = (quot < CalibTotalW'(EAR_FLOOR)) ? EAR_FLOOR : quot[15:0];

   // Calibration bookkeeping
   always_comb begin
      seen_in    = seen_ff;
      done_in    = done_ff;
      learned_in = learned_ff;
      if (!done_ff) begin
         seen_in = seen_ff + CalibSeenW'(1);
         if (seen_in >= CalibSeenW'(CALIB_COUNT)) begin
            learned_in = thr_calc;
            done_in    = 1'b1;
         end
      end
   end

   assign limit   = done_in ? learned_in : cfg.ear_default;
   assign elapsed = in_item.time_ms - since_ff;
   assign yaw_abs = in_item.yaw_avg[14] ? 15'(-in_item.yaw_avg) : 15'(in_item.yaw_avg);

   // Closure timing, blink count and status priority
   always_comb begin
      shut_in   = shut_ff;
      since_in  = since_ff;
      blinks_in = blinks_ff;
      status    = STATUS_OK;
      if (in_item.eye_avg < limit) begin
         if (!shut_ff) begin
            since_in = in_item.time_ms;
            shut_in  = 1'b1;
         end else if (elapsed >= 32'(cfg.closed_ms)) begin
            status = STATUS_ALERT;
         end
      end else if (shut_ff) begin
         if (blinks_ff != 16'hFFFF) begin
            blinks_in = blinks_ff + 16'd1;
         end
         shut_in = 1'b0;
      end
      if (in_item.mouth_avg > cfg.mar_thr) begin
         status = STATUS_YAWN;
      end
      if (yaw_abs > {1'b0, cfg.yaw_thr}) begin
         status = STATUS_SIDE;
      end
      if (in_item.pitch_down) begin
         status = STATUS_DOWN;
      end
   end

   // Update state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         shut_ff    <= 1'b0;
         since_ff   <= '0;
         blinks_ff  <= '0;
         seen_ff    <= '0;
         total_ff   <= '0;
         done_ff    <= 1'b0;
         learned_ff <= '0;
         valid_ff   <= 1'b0;
      end else if (accept) begin
         shut_ff    <= shut_in;
         since_ff   <= since_in;
         blinks_ff  <= blinks_in;
         seen_ff    <= seen_in;
         if (!done_ff) begin
            total_ff <= total_in;
         end
         done_ff    <= done_in;
         learned_ff <= learned_in;
         valid_ff   <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.status        <= status;
         item_ff.blinks        <= blinks_in;
         item_ff.smoothed_eye  <= in_item.eye_avg;
         item_ff.eye_limit     <= limit;
         item_ff.is_calibrated <= done_in;
      end
   end

endmodule

// File: design/drowsiness_alert_classifier.sv
// Top level of the drowsiness alert classifier: register file, smoothing
// stage and classification stage. Depends on dac_pkg, dac_smooth, dac_classify.
//
//   channel  direction  item
//   req_     in         one face measurement per frame (96-bit tdata)
//   rsp_     out        one status result per measurement (56-bit tdata)
//   csr_     in         register write: index and data
//
// One item per cycle sustained while rsp_tready stays high. The smoothing
// register loads at the accepting edge and the result register loads from it,
// after the calibration and status logic; rsp_tvalid is its valid flag.
// Reset clears averages, counters and calibration, and loads register defaults.
// Each stage holds its item while the stage after it is full and stalled, so a
// stall on rsp_tready backs up into req_tready only once both stages are occupied.
module drowsiness_alert_classifier #(
   parameter int CALIB_COUNT = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // eye_ratio[15:0], mouth_ratio[31:16], yaw_angle[46:32], pitch_angle[61:47],
   // time_ms[93:62], zero[95:94]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], blinks[18:3], smoothed_eye[34:19], eye_limit[50:35],
   // is_calibrated[51], zero[55:52]
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import dac_pkg::*;

   cfg_type    cfg_ff;
   logic       mid_valid;
   logic       mid_ready;
   smooth_type mid_item;
   result_type rsp_item;

   assign csr_ready = 1'b1;

   // Register file: writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha       <= ALPHA_RESET;
         cfg_ff.ear_default <= EAR_DEF_RESET;
         cfg_ff.mar_thr     <= MAR_RESET;
         cfg_ff.yaw_thr     <= YAW_THR_RESET;
         cfg_ff.pitch_thr   <= PITCH_THR_RESET;
         cfg_ff.closed_ms   <= CLOSED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ALPHA:     cfg_ff.alpha       <= csr_wdata[8:0];
            REG_EAR_DEF:   cfg_ff.ear_default <= csr_wdata;
            REG_MAR:       cfg_ff.mar_thr     <= csr_wdata;
            REG_YAW_THR:   cfg_ff.yaw_thr     <= csr_wdata[13:0];
            REG_PITCH_THR: cfg_ff.pitch_thr   <= $signed(csr_wdata[14:0]);
            REG_CLOSED:    cfg_ff.closed_ms   <= csr_wdata;
            default: ;
         endcase
      end
   end

   dac_smooth u_smooth (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .eye_ratio   (req_tdata[15:0]),
      .mouth_ratio (req_tdata[31:16]),
      .yaw_angle   ($signed(req_tdata[46:32])),
      .pitch_angle ($signed(req_tdata[61:47])),
      .time_ms     (req_tdata[93:62]),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_item    (mid_item)
   );

   dac_classify #(
      .CALIB_COUNT (CALIB_COUNT)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // Pack the result, first field lowest
   assign rsp_tdata = {4'b0000, rsp_item.is_calibrated, rsp_item.eye_limit,
                       rsp_item.smoothed_eye, rsp_item.blinks, rsp_item.status};

endmodule

// File: design/dac_checker.sv
// Port-level checks for the drowsiness alert classifier, bound to the top level.
// Depends on dac_pkg and drowsiness_alert_classifier.
module dac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import dac_pkg::*;

   // No result pending just after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= STATUS_DOWN))
      else $error("status code out of range");

   // Calibration, once shown, stays on a result shown straight after it
   a_calib_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[51] |=> !rsp_tvalid || rsp_tdata[51])
      else $error("calibration flag dropped");

   // An empty output lets the input flow
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind drowsiness_alert_classifier dac_checker u_dac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/testbench.sv
// Self-checking testbench for drowsiness_alert_classifier: directed frames, then
// random frame sequences under several register settings, checked by a predictor.
// Depends on dac_pkg and the design top level, which needs dac_smooth and dac_classify.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dac_pkg::*;

   localparam int WARMUP_LEN    = 30;
   localparam int SETTLE_CYCLES = 6;
   localparam int NUM_ROWS      = 21;
   localparam int NUM_SETS      = 7;

   // One face measurement as it travels on req_tdata
   typedef struct packed {
      logic [15:0]        eye;
      logic [15:0]        mouth;
      logic signed [14:0] yaw;
      logic signed [14:0] pitch;
      logic [31:0]        stamp;
   } frame_type;

   typedef struct {
      frame_type  f;
      bit         typed;
      result_type want;
   } plan_row_type;

   localparam result_type UNTYPED = '{STATUS_OK, 16'd0, 16'd0, 16'd0, 1'b0};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // Predictor copy of the registers
   logic [8:0]         cfg_alpha;
   logic [15:0]        cfg_ear_def;
   logic [15:0]        cfg_mar;
   logic [13:0]        cfg_yaw;
   logic signed [14:0] cfg_pitch;
   logic [15:0]        cfg_closed;

   // Predictor copy of the tracking state
   logic [15:0]        eye_mean;
   logic [15:0]        mouth_mean;
   logic signed [14:0] yaw_mean;
   logic               lids_down;
   logic [31:0]        lids_down_at;
   logic [15:0]        blink_count;
   logic [4:0]         warmup_seen;
   logic [20:0]        calib_sum;
   logic               calibrated;
   logic [15:0]        learned_limit;

   // Random sequence state
   logic [31:0] frame_clock;
   bit          lid_shut;
   int          lid_left;
   int          yawn_left;

   // Pending expectations, oldest at ring_rd
   result_type  awaited_ring [256];
   logic [7:0]  ring_wr;
   logic [7:0]  ring_rd;
   int unsigned errors;
   int unsigned frames_sent;
   int unsigned status_count [5];
   int          idle_pct;
   bit          calm_tail;

   reg_index_type reg_order [6] = '{REG_ALPHA, REG_EAR_DEF, REG_MAR,
                                    REG_YAW_THR, REG_PITCH_THR, REG_CLOSED};
   logic [15:0]   csr_plan [NUM_SETS][6] = '{
      '{16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd11520, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'(-11520), 16'hFFFF},
      '{16'd77, 16'd1024, 16'd2458, 16'd6400, 16'd5120, 16'd1000},
      '{16'd511, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd300, 16'd2000, 16'd2000, 16'd5000, 16'(-2000), 16'd200},
      '{16'd128, 16'd900, 16'd3000, 16'd8000, 16'd9000, 16'd500}
   };

   // Directed frames; expectations typed in only where they are plain to see
   plan_row_type plan [NUM_ROWS] = '{
      '{'{16'd0, 16'd0, 0, 0, 32'd0}, 1'b1,
        '{STATUS_OK, 16'd0, 16'd0, 16'd1024, 1'b0}},
      '{'{16'd0, 16'd0, 0, 11520, 32'd10}, 1'b1,
        '{STATUS_DOWN, 16'd0, 16'd0, 16'd1024, 1'b0}},
      '{'{16'd0, 16'd0, 0, 0, 32'd2000}, 1'b1,
        '{STATUS_ALERT, 16'd0, 16'd0, 16'd1024, 1'b0}},
      '{'{16'd0, 16'hFFFF, 0, 0, 32'd2001}, 1'b1,
        '{STATUS_YAWN, 16'd0, 16'd0, 16'd1024, 1'b0}},
      '{'{16'd0, 16'd0, 11520, 0, 32'd2002}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, 11520, 0, 32'd2003}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, -11520, 0, 32'd2004}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, -11520, -11520, 32'd2005}, 1'b0, UNTYPED},
      '{'{16'hFFFF, 16'd0, 0, 0, 32'd2040}, 1'b0, UNTYPED},
      '{'{16'hFFFF, 16'd0, 0, 0, 32'd2080}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, 0, 0, 32'hFFFF_FFF0}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, 0, 0, 32'h0000_0010}, 1'b0, UNTYPED},
      '{'{16'd0, 16'd0, 0, 0, 32'h0000_0005}, 1'b0, UNTYPED},
      '{'{16'hFFFF, 16'hFFFF, 16383, -16384, 32'hFFFF_FFFF}, 1'b0, UNTYPED},
      '{'{16'hFFFF, 16'd0, -16384, 16383, 32'd0}, 1'b0, UNTYPED},
      '{'{16'h5555, 16'hAAAA, 15'h2AAA, 15'h5555, 32'h5555_5555}, 1'b0, UNTYPED},
      '{'{16'hAAAA, 16'h5555, 15'h5555, 15'h2AAA, 32'hAAAA_AAAA}, 1'b0, UNTYPED},
      '{'{16'd1200, 16'd1000, 0, 0, 32'd100}, 1'b0, UNTYPED},
      '{'{16'd1200, 16'd1000, 0, 0, 32'd133}, 1'b0, UNTYPED},
      '{'{16'd1200, 16'd1000, 0, 0, 32'd166}, 1'b0, UNTYPED},
      '{'{16'd1200, 16'd1000, 0, 0, 32'd200}, 1'b0, UNTYPED}
   };

   drowsiness_alert_classifier #(.CALIB_COUNT(WARMUP_LEN)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Advance the predictor by one frame and return the result it must give
   function automatic result_type classify_frame(input frame_type f);
      longint     wt;
      longint     acc;
      int         ayaw;
      logic [15:0] lim;
      status_type st;
      wt = (cfg_alpha > ALPHA_FULL) ? longint'(ALPHA_FULL) : longint'(cfg_alpha);

      // Exponential averages; the signed one floors toward minus infinity
      acc        = longint'(eye_mean) * (256 - wt) + longint'(f.eye) * wt;
      eye_mean   = 16'(acc >> 8);
      acc        = longint'(mouth_mean) * (256 - wt) + longint'(f.mouth) * wt;
      mouth_mean = 16'(acc >> 8);
      acc        = longint'(yaw_mean) * (256 - wt) + longint'(f.yaw) * wt;
      yaw_mean   = 15'(acc >>> 8);

      // Learn the eye threshold over the first frames, with a floor
      if (!calibrated) begin
         calib_sum   = 21'(calib_sum + eye_mean);
         warmup_seen = 5'(warmup_seen + 1);
         if (warmup_seen >= WARMUP_LEN) begin
            acc = longint'(calib_sum) * 11 / (20 * longint'(warmup_seen));
            if (acc < longint'(EAR_FLOOR)) acc = longint'(EAR_FLOOR);
            learned_limit = 16'(acc);
            calibrated    = 1'b1;
         end
      end
      lim = calibrated ? learned_limit : cfg_ear_def;

      // Time the closure; count a blink on reopening
      st = STATUS_OK;
      if (eye_mean < lim) begin
         if (!lids_down) begin
            lids_down_at = f.stamp;
            lids_down    = 1'b1;
         end else if (32'(f.stamp - lids_down_at) >= {16'd0, cfg_closed}) begin
            st = STATUS_ALERT;
         end
      end else if (lids_down) begin
         if (blink_count != 16'hFFFF) blink_count++;
         lids_down = 1'b0;
      end

      // Later checks override earlier ones
      if (mouth_mean > cfg_mar) st = STATUS_YAWN;
      ayaw = (yaw_mean < 0) ? -int'(yaw_mean) : int'(yaw_mean);
      if (ayaw > int'(cfg_yaw)) st = STATUS_SIDE;
      if (f.pitch > cfg_pitch) st = STATUS_DOWN;
      return '{st, blink_count, eye_mean, lim, calibrated};
   endfunction

   // Mostly plausible video: lid episodes, yawns, glances aside and down
   function automatic frame_type make_frame();
      frame_type f;
      int        roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         f.eye   = 16'($urandom);
         f.mouth = 16'($urandom);
         f.yaw   = 15'($urandom);
         f.pitch = 15'($urandom);
         f.stamp = $urandom;
         return f;
      end
      if (lid_left == 0) begin
         lid_shut = !lid_shut;
         lid_left = lid_shut ? span(1, 60) : span(3, 40);
      end
      lid_left--;
      if (yawn_left == 0 && $urandom_range(0, 99) < 3) yawn_left = span(5, 25);
      frame_clock += 32'(span(15, 60));
      if (roll < 11) frame_clock -= 32'(span(1, 5000));
      else if (roll < 13) frame_clock += 32'(span(1000, 100000));
      f.stamp = frame_clock;
      f.eye   = 16'(lid_shut ? span(0, 450) : span(900, 1800));
      f.mouth = 16'(yawn_left > 0 ? span(3000, 9000) : span(500, 1600));
      if (yawn_left > 0) yawn_left--;
      if ($urandom_range(0, 9) == 0)
         f.yaw = 15'(($urandom_range(0, 1) ? 1 : -1) * span(6000, 11520));
      else
         f.yaw = 15'(span(-2500, 2500));
      f.pitch = 15'($urandom_range(0, 99) < 8 ? span(4000, 11520) : span(-4000, 3000));
      return f;
   endfunction

   // Offer one frame, hold it until taken, then record what must come back
   task automatic send_frame(input frame_type f, input bit typed, input result_type want);
      result_type got_pred;
      if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, f.stamp, f.pitch, f.yaw, f.mouth, f.eye};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got_pred = classify_frame(f);
      awaited_ring[ring_wr] = typed ? want : got_pred;
      ring_wr = ring_wr + 8'd1;
      frames_sent++;
   endtask

   // Stop offering frames and let the pipeline empty before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (ring_wr != ring_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ALPHA:     cfg_alpha   = d[8:0];
         REG_EAR_DEF:   cfg_ear_def = d;
         REG_MAR:       cfg_mar     = d;
         REG_YAW_THR:   cfg_yaw     = d[13:0];
         REG_PITCH_THR: cfg_pitch   = signed'(d[14:0]);
         REG_CLOSED:    cfg_closed  = d;
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned exp_v, got_v);
      if (exp_v != got_v) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endtask

   // Compare every accepted result with the oldest pending expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ring_wr == ring_rd) begin
            errors++;
            $display("%0t: result with no frame pending, expected none, got %h",
                     $time, rsp_tdata);
         end else begin
            want = awaited_ring[ring_rd];
            ring_rd = ring_rd + 8'd1;
            check_field("status", want.status, rsp_tdata[2:0]);
            check_field("blinks", want.blinks, rsp_tdata[18:3]);
            check_field("smoothed_eye", want.smoothed_eye, rsp_tdata[34:19]);
            check_field("eye_limit", want.eye_limit, rsp_tdata[50:35]);
            check_field("is_calibrated", want.is_calibrated, rsp_tdata[51]);
            if (rsp_tdata[2:0] < 3'd5) status_count[rsp_tdata[2:0]]++;
         end
      end
   end

   // Result side back-pressure in bursts, none in the final phase
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_ALPHA;
      csr_wdata  <= '0;
      errors = 0;
      frames_sent = 0;
      ring_wr = '0;
      ring_rd = '0;
      calm_tail = 1'b0;
      idle_pct = 25;
      foreach (status_count[i]) status_count[i] = 0;
      cfg_alpha   = ALPHA_RESET;
      cfg_ear_def = EAR_DEF_RESET;
      cfg_mar     = MAR_RESET;
      cfg_yaw     = YAW_THR_RESET;
      cfg_pitch   = PITCH_THR_RESET;
      cfg_closed  = CLOSED_RESET;
      eye_mean = '0; mouth_mean = '0; yaw_mean = '0;
      lids_down = 1'b0; lids_down_at = '0; blink_count = '0;
      warmup_seen = '0; calib_sum = '0; calibrated = 1'b0; learned_limit = '0;
      lid_shut = 1'b0; lid_left = 0; yawn_left = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values
      foreach (plan[i]) send_frame(plan[i].f, plan[i].typed, plan[i].want);

      // Random phases, each under its own register setting
      for (int s = 0; s < NUM_SETS; s++) begin
         drain();
         if (s == 3 || s == 4)
            for (int i = 1; i < 6; i++) csr_plan[s][i] = 16'($urandom);
         if (s == 4) csr_plan[s][0] = 16'($urandom);
         foreach (reg_order[i]) write_reg(reg_order[i], csr_plan[s][i]);
         csr_valid <= 1'b0;
         calm_tail   = (s == NUM_SETS - 1);
         idle_pct    = $urandom_range(0, 1) ? 30 : 0;
         frame_clock = (s == 4) ? 32'hFFFF_EC00 : $urandom;
         repeat (s == 1 ? 100 : 300) send_frame(make_frame(), 1'b0, UNTYPED);
      end
      drain();

      $display("Sent %0d frames across the reset values and %0d register settings.",
               frames_sent, NUM_SETS);
      $display("Seen: ok %0d, alert %0d, yawn %0d, side %0d, down %0d; blinks %0d.",
               status_count[0], status_count[1], status_count[2], status_count[3],
               status_count[4], blink_count);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
